// ===== hdl/quicksort_engine_unit_assert.svh =====
// ---------------------------------------------------------------------------
// quicksort_engine_unit assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef QUICKSORT_ENGINE_UNIT_ASSERT_SVH
`define QUICKSORT_ENGINE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define QSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed (same cycle)");
// next-cycle implication
`define QSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed (next cycle)");
`else
`define QSE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define QSE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/qse_pkg.sv =====
// ---------------------------------------------------------------------------
// qse_pkg
// Shared types and constants of the quicksort engine.
// ---------------------------------------------------------------------------
package qse_pkg;

   localparam int VALUE_W = 32;

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000_0000_0000_0001,
      ST_HI_RD    = 15'b000_0000_0000_0010,
      ST_PIV      = 15'b000_0000_0000_0100,
      ST_SCAN_RD  = 15'b000_0000_0000_1000,
      ST_SCAN_CMP = 15'b000_0000_0001_0000,
      ST_SWAP_W1  = 15'b000_0000_0010_0000,
      ST_SWAP_W2  = 15'b000_0000_0100_0000,
      ST_FIN_RD   = 15'b000_0000_1000_0000,
      ST_FIN_W1   = 15'b000_0001_0000_0000,
      ST_FIN_W2   = 15'b000_0010_0000_0000,
      ST_PUSH1    = 15'b000_0100_0000_0000,
      ST_PUSH2    = 15'b000_1000_0000_0000,
      ST_POP_RD   = 15'b001_0000_0000_0000,
      ST_POP_DAT  = 15'b010_0000_0000_0000,
      ST_EMIT     = 15'b100_0000_0000_0000
   } qse_state_type;

endpackage

// ===== hdl/qse_ram.sv =====
// ---------------------------------------------------------------------------
// qse_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module qse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/quicksort_engine_unit.sv =====
// ---------------------------------------------------------------------------
// quicksort_engine_unit
// Collects signed words into a store, sorts them and streams them out.
// ---------------------------------------------------------------------------
// Usage:
//   Input: a word is taken on a rising edge with start high and busy low.
//   Words may arrive back to back; req_last_item closes the set and starts the
//   sort. Words arriving with the store full are dropped and flagged.
//   Sort: in-place quicksort, Lomuto partition, over the element RAM with a
//   RAM-based range stack. Each scanned element is read and compared; a swap
//   adds a read and two writes. Each partition adds a pivot read, the final
//   swap (skipped when the pivot stays put) and a stack push/pop; trivial
//   ranges are popped and skipped. The single RAM read port serialises these steps.
//   Output: one word per cycle on rsp_strobe, each shown by a registered read
//   from the emit state, entered after the last sort step or once a one-word
//   set is taken; the last is marked by rsp_last_result. busy falls as it is shown.
//   The receiver cannot stall; words are never held.
//   csr_write_data selects order (1 = largest first); the user must write it only when idle (not enforced).
//   Reset: synchronous, empties the store, clears the flag, sets
//   descending order. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "quicksort_engine_unit_assert.svh"

module quicksort_engine_unit import qse_pkg::*; #(
   parameter int MAX_ITEMS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last_item,
   input  logic                      csr_write_en,
   input  logic                      csr_write_data,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_sorted_value,
   output logic                      rsp_last_result,
   output logic                      rsp_overflow
);

   localparam int AW  = $clog2(MAX_ITEMS);
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int SW  = CW + 1;                 // signed index, -1 .. MAX_ITEMS
   localparam int SD  = 2 * MAX_ITEMS + 2;
   localparam int SAW = $clog2(SD);
   localparam int TW  = $clog2(SD + 1);

   qse_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          desc_ff, desc_in;
   logic signed [SW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [SW-1:0] scan_ff, scan_in, store_ff, store_in;
   logic signed [VALUE_W-1:0] pivot_ff, pivot_in, val_ff, val_in;
   logic [TW-1:0] top_ff, top_in;
   logic [CW-1:0] emit_k_ff, emit_k_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic               e_wr_en, e_rd_en;
   logic [AW-1:0]      e_wr_addr, e_rd_addr;
   logic [VALUE_W-1:0] e_wr_data, e_rd_data;
   logic               s_wr_en, s_rd_en;
   logic [SAW-1:0]     s_wr_addr, s_rd_addr;
   logic [2*SW-1:0]    s_wr_data, s_rd_data;

   logic                 full;
   logic [CW-1:0]        n_cnt;
   logic signed [SW-1:0] scan_inc, store_inc, store_dec;
   logic                 scan_less, big_left;
   logic [2*SW-1:0]      left_rng, right_rng;
   logic [TW-1:0]        top_dec;
   logic                 stack_full;
   logic signed [SW-1:0] pop_lo, pop_hi;
   logic [CW-1:0]        emit_rev;

   assign full       = (count_ff == CW'(MAX_ITEMS));
   assign n_cnt      = full ? count_ff : count_ff + CW'(1);
   assign scan_inc   = scan_ff + SW'(1);
   assign store_inc  = store_ff + SW'(1);
   assign store_dec  = store_ff - SW'(1);
   assign scan_less  = $signed(e_rd_data) < pivot_ff;
   assign big_left   = (store_ff - lo_ff) > (hi_ff - store_ff);
   assign left_rng   = {lo_ff, store_dec};
   assign right_rng  = {store_inc, hi_ff};
   assign top_dec    = top_ff - TW'(1);
   assign stack_full = ((TW+1)'(top_ff) + (TW+1)'(2)) > (TW+1)'(SD);
   assign pop_lo     = $signed(s_rd_data[2*SW-1:SW]);
   assign pop_hi     = $signed(s_rd_data[SW-1:0]);
   assign emit_rev   = count_ff - CW'(1) - emit_k_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      desc_in       = csr_write_en ? csr_write_data : desc_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      scan_in       = scan_ff;
      store_in      = store_ff;
      pivot_in      = pivot_ff;
      val_in        = val_ff;
      top_in        = top_ff;
      emit_k_in     = emit_k_ff;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_ovf_in    = rsp_ovf_ff;
      e_wr_en       = 1'b0;
      e_wr_addr     = store_ff[AW-1:0];
      e_wr_data     = val_ff;
      e_rd_en       = 1'b0;
      e_rd_addr     = scan_ff[AW-1:0];
      s_wr_en       = 1'b0;
      s_wr_addr     = top_ff[SAW-1:0];
      s_wr_data     = big_left ? left_rng : right_rng;
      s_rd_en       = 1'b0;
      s_rd_addr     = top_dec[SAW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  e_wr_en   = 1'b1;
                  e_wr_addr = count_ff[AW-1:0];
                  e_wr_data = req_value;
                  count_in  = count_ff + CW'(1);
               end
               if (req_last_item) begin
                  if (n_cnt > CW'(1)) begin
                     lo_in    = '0;
                     hi_in    = $signed({1'b0, n_cnt}) - SW'(1);
                     top_in   = '0;
                     state_in = ST_HI_RD;
                  end else begin
                     emit_k_in = '0;
                     state_in  = ST_EMIT;
                  end
               end
            end
         end
         ST_HI_RD: begin
            e_rd_en   = 1'b1;
            e_rd_addr = hi_ff[AW-1:0];
            state_in  = ST_PIV;
         end
         ST_PIV: begin
            pivot_in = $signed(e_rd_data);
            scan_in  = lo_ff;
            store_in = lo_ff;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            e_rd_en   = 1'b1;
            e_rd_addr = scan_ff[AW-1:0];
            state_in  = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (scan_less && (store_ff != scan_ff)) begin
               val_in    = $signed(e_rd_data);
               e_rd_en   = 1'b1;
               e_rd_addr = store_ff[AW-1:0];
               state_in  = ST_SWAP_W1;
            end else begin
               if (scan_less) begin
                  store_in = store_inc;
               end
               scan_in  = scan_inc;
               state_in = (scan_inc < hi_ff) ? ST_SCAN_RD : ST_FIN_RD;
            end
         end
         ST_SWAP_W1: begin
            // old store word goes to the scan slot
            e_wr_en   = 1'b1;
            e_wr_addr = scan_ff[AW-1:0];
            e_wr_data = e_rd_data;
            state_in  = ST_SWAP_W2;
         end
         ST_SWAP_W2: begin
            e_wr_en   = 1'b1;
            e_wr_addr = store_ff[AW-1:0];
            e_wr_data = val_ff;
            store_in  = store_inc;
            scan_in   = scan_inc;
            state_in  = (scan_inc < hi_ff) ? ST_SCAN_RD : ST_FIN_RD;
         end
         ST_FIN_RD: begin
            if (store_ff == hi_ff) begin
               state_in = ST_PUSH1;
            end else begin
               e_rd_en   = 1'b1;
               e_rd_addr = store_ff[AW-1:0];
               state_in  = ST_FIN_W1;
            end
         end
         ST_FIN_W1: begin
            e_wr_en   = 1'b1;
            e_wr_addr = hi_ff[AW-1:0];
            e_wr_data = e_rd_data;
            state_in  = ST_FIN_W2;
         end
         ST_FIN_W2: begin
            e_wr_en   = 1'b1;
            e_wr_addr = store_ff[AW-1:0];
            e_wr_data = pivot_ff;
            state_in  = ST_PUSH1;
         end
         ST_PUSH1: begin
            if (stack_full) begin
               emit_k_in = '0;
               state_in  = ST_EMIT;
            end else begin
               // larger side first, smaller popped next
               s_wr_en   = 1'b1;
               s_wr_data = big_left ? left_rng : right_rng;
               top_in    = top_ff + TW'(1);
               state_in  = ST_PUSH2;
            end
         end
         ST_PUSH2: begin
            s_wr_en   = 1'b1;
            s_wr_data = big_left ? right_rng : left_rng;
            top_in    = top_ff + TW'(1);
            state_in  = ST_POP_RD;
         end
         ST_POP_RD: begin
            s_rd_en  = 1'b1;
            top_in   = top_dec;
            state_in = ST_POP_DAT;
         end
         ST_POP_DAT: begin
            lo_in = pop_lo;
            hi_in = pop_hi;
            if (pop_lo >= pop_hi) begin
               if (top_ff == '0) begin
                  emit_k_in = '0;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ST_POP_RD;
               end
            end else begin
               state_in = ST_HI_RD;
            end
         end
         ST_EMIT: begin
            e_rd_en       = 1'b1;
            e_rd_addr     = desc_ff ? emit_rev[AW-1:0] : emit_k_ff[AW-1:0];
            rsp_strobe_in = 1'b1;
            rsp_ovf_in    = ovf_ff;
            emit_k_in     = emit_k_ff + CW'(1);
            if (emit_k_ff == count_ff - CW'(1)) begin
               rsp_last_in = 1'b1;
               count_in    = '0;
               ovf_in      = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         desc_ff       <= 1'b1;
         top_ff        <= '0;
         emit_k_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         desc_ff       <= desc_in;
         top_ff        <= top_in;
         emit_k_ff     <= emit_k_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
      end
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      scan_ff    <= scan_in;
      store_ff   <= store_in;
      pivot_ff   <= pivot_in;
      val_ff     <= val_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   qse_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_en   (e_rd_en),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   qse_ram #(
      .WIDTH (2 * SW),
      .DEPTH (SD)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sorted_value = $signed(e_rd_data);
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // a set streams out without gaps and ends with a quiet cycle
   `QSE_ASSERT_NXT(a_run_contig, clock, reset, rsp_strobe_ff && !rsp_last_ff, rsp_strobe_ff)
   `QSE_ASSERT_NXT(a_run_end, clock, reset, rsp_strobe_ff && rsp_last_ff, !rsp_strobe_ff)
   `QSE_ASSERT_IMP(a_store_le_scan, clock, reset, (state_ff == ST_SCAN_RD) || (state_ff == ST_SCAN_CMP) || (state_ff == ST_SWAP_W1) || (state_ff == ST_SWAP_W2), store_ff <= scan_ff)
   `QSE_ASSERT_IMP(a_emit_in_set, clock, reset, state_ff == ST_EMIT, emit_k_ff < count_ff)

endmodule
